// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by cubic_spline_segment_eval.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cspl_pkg.sv =====
// ----------------------------------------------------------------------------
// cspl_pkg
// Types, constants and the fixed-point weight multiply of the spline evaluator.
// ----------------------------------------------------------------------------
package cspl_pkg;

  localparam int WFRAC      = 30;
  localparam int SPLIT_BITS = 24;
  localparam int WT_W       = 31;
  localparam int N_W        = 36;
  localparam int H_W        = 34;
  localparam int C_W        = 32;

  typedef logic [WT_W-1:0] wt_t;
  typedef logic signed [N_W-1:0] num_t;
  typedef logic signed [H_W-1:0] half_t;
  typedef logic signed [C_W-1:0] coef_t;

  localparam logic [1:0] MODE_BEZIER  = 2'd0;
  localparam logic [1:0] MODE_BSPLINE = 2'd1;
  localparam logic [1:0] MODE_CATROM  = 2'd2;

  localparam wt_t   WONE      = 31'h4000_0000;
  localparam num_t  ONE_N     = 36'sh0_4000_0000;
  localparam half_t DIV3_BIAS = 34'sd768;
  localparam coef_t DIV3_OFS  = 32'sd256;
  localparam logic [31:0] DIV3_MUL = 32'hAAAA_AAAB;

  // Rounded Q30 product of two weights in [0, 1].
  function automatic wt_t mulq(input wt_t a, input wt_t b);
    logic [2*WT_W-1:0] p;
    p = {{WT_W{1'b0}}, a} * {{WT_W{1'b0}}, b};
    p = p + ((2*WT_W)'(1) << (WFRAC - 1));
    return p[WFRAC +: WT_W];
  endfunction

endpackage

// ===== rtl/cubic_spline_segment_eval.sv =====
// ----------------------------------------------------------------------------
// cubic_spline_segment_eval
// Cubic Bezier, uniform B-spline and Catmull-Rom segment evaluation.
// ----------------------------------------------------------------------------
// Each input transfer carries four signed control values and a parameter t
// (clamped to 1.0); the block returns one saturated weighted sum per transfer.
// The basis is chosen by basis_mode, which must be written by the user only while
// the block is idle; the block itself does not enforce this. Codes other than
// B-spline and Catmull-Rom evaluate as Bezier. The pipeline has eight register
// stages, and a new item is taken in every cycle unless back-pressure holds the
// output: the weight multiplies, the divide by three and the control value
// products each own a stage. Back-pressure on the output stalls the stages that hold data.
module cubic_spline_segment_eval #(
  parameter int VALUE_WIDTH     = 32,
  parameter int PARAM_FRAC_BITS = 16,
  localparam int IN_W   = 4 * VALUE_WIDTH + PARAM_FRAC_BITS + 1,
  localparam int IN_TDW = ((IN_W + 7) / 8) * 8,
  localparam int OUT_TDW = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_wdata,
  input  logic               s_tvalid,
  output logic               s_tready,
  // Fields from bit 0 up: first_value, second_value, third_value,
  // fourth_value, curve_param, zero fill.
  input  logic [IN_TDW-1:0]  s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // Fields from bit 0 up: curve_value, zero fill.
  output logic [OUT_TDW-1:0] m_tdata
);

`include "assert_macros.svh"

  localparam int VW    = VALUE_WIDTH;
  localparam int TW    = PARAM_FRAC_BITS + 1;
  localparam int SPL   = cspl_pkg::SPLIT_BITS;
  localparam int VH_W  = (VW > SPL) ? VW - SPL : 1;
  localparam int XW    = SPL + VH_W;
  localparam int PL_W  = cspl_pkg::C_W + SPL + 1;
  localparam int PH_W  = cspl_pkg::C_W + VH_W;
  localparam int LO_W  = PL_W + 2;
  localparam int HI_W  = PH_W + 2;
  localparam int LQ_W  = LO_W - SPL;
  localparam int RW    = HI_W + 1;
  localparam int NST   = 7;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [TW-1:0] TONE = TW'(1) << PARAM_FRAC_BITS;

  logic [1:0]     basis_mode;
  logic [NST-1:0] vld;
  logic [NST:0]   adv;
  logic           out_valid;
  logic [VW-1:0]  out_data;

  logic signed [VW-1:0] v1 [4];
  logic signed [VW-1:0] v2 [4];
  logic signed [VW-1:0] v3 [4];
  logic signed [VW-1:0] v4 [4];
  logic signed [VW-1:0] v5 [4];
  cspl_pkg::wt_t t1, u1, t2, u2, tt2, uu2;
  cspl_pkg::wt_t t3, tt3, ttt3, uuu3, uut3, utt3;
  cspl_pkg::half_t h4 [4];
  logic            div3_4;
  cspl_pkg::coef_t c5 [4];
  logic signed [PL_W-1:0] pl6 [4];
  logic signed [PH_W-1:0] ph6 [4];
  logic signed [LO_W-1:0] lo7;
  logic signed [HI_W-1:0] hi7;

  logic [TW-1:0]   t_in;
  cspl_pkg::wt_t   t_ext;
  cspl_pkg::num_t  ts, tts, ttts;
  cspl_pkg::half_t h_next [4];
  cspl_pkg::coef_t c_next [4];
  logic signed [LO_W-1:0] lo_next;
  logic signed [HI_W-1:0] hi_next;
  logic signed [LO_W-1:0] lo_rnd;
  logic signed [LQ_W-1:0] lq;
  logic signed [RW-1:0]   rsum, rsh;
  logic [VW-1:0]          res_next;

  // Handshake: a stage moves when it is empty or the stage after it moves.
  always_comb begin
    adv[NST] = !out_valid || m_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDW'(out_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_mode <= cspl_pkg::MODE_BEZIER;
      vld        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        basis_mode <= cfg_wdata;
      end
      if (adv[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (adv[NST]) begin
        out_valid <= vld[NST-1];
      end
    end
  end

  // Stage 1: unpack, clamp t and move it to Q30.
  assign t_in  = s_tdata[4*VW +: TW];
  assign t_ext = (t_in > TONE) ? cspl_pkg::WONE
                 : (cspl_pkg::WT_W'(t_in) << (cspl_pkg::WFRAC - PARAM_FRAC_BITS));

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 4; i++) begin
        v1[i] <= $signed(s_tdata[i*VW +: VW]);
      end
      t1 <= t_ext;
      u1 <= cspl_pkg::WONE - t_ext;
    end
  end

  // Stage 2: squares.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      v2  <= v1;
      t2  <= t1;
      u2  <= u1;
      tt2 <= cspl_pkg::mulq(t1, t1);
      uu2 <= cspl_pkg::mulq(u1, u1);
    end
  end

  // Stage 3: cubes and mixed terms.
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      v3   <= v2;
      t3   <= t2;
      tt3  <= tt2;
      ttt3 <= cspl_pkg::mulq(tt2, t2);
      uuu3 <= cspl_pkg::mulq(uu2, u2);
      uut3 <= cspl_pkg::mulq(uu2, t2);
      utt3 <= cspl_pkg::mulq(u2, tt2);
    end
  end

  // Stage 4: basis numerators, halved with rounding toward minus infinity.
  assign ts   = $signed(cspl_pkg::N_W'(t3));
  assign tts  = $signed(cspl_pkg::N_W'(tt3));
  assign ttts = $signed(cspl_pkg::N_W'(ttt3));

  always_comb begin
    cspl_pkg::num_t n [4];
    unique case (basis_mode)
      cspl_pkg::MODE_BSPLINE: begin
        n[0] = cspl_pkg::ONE_N - ts * 36'sd3 + tts * 36'sd3 - ttts + 36'sd3;
        n[1] = cspl_pkg::ONE_N * 36'sd4 - tts * 36'sd6 + ttts * 36'sd3 + 36'sd3;
        n[2] = cspl_pkg::ONE_N + ts * 36'sd3 + tts * 36'sd3 - ttts * 36'sd3 + 36'sd3;
        n[3] = ttts + 36'sd3;
      end
      cspl_pkg::MODE_CATROM: begin
        n[0] = tts * 36'sd2 - ts - ttts + 36'sd1;
        n[1] = cspl_pkg::ONE_N * 36'sd2 - tts * 36'sd5 + ttts * 36'sd3 + 36'sd1;
        n[2] = ts + tts * 36'sd4 - ttts * 36'sd3 + 36'sd1;
        n[3] = ttts - tts + 36'sd1;
      end
      default: begin
        n[0] = $signed(cspl_pkg::N_W'(uuu3)) <<< 1;
        n[1] = ($signed(cspl_pkg::N_W'(uut3)) * 36'sd3) <<< 1;
        n[2] = ($signed(cspl_pkg::N_W'(utt3)) * 36'sd3) <<< 1;
        n[3] = ttts <<< 1;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      h_next[i] = cspl_pkg::H_W'(n[i] >>> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      v4     <= v3;
      h4     <= h_next;
      div3_4 <= (basis_mode == cspl_pkg::MODE_BSPLINE);
    end
  end

  // Stage 5: exact floor division by three for the B-spline weights.
  always_comb begin
    cspl_pkg::half_t zs;
    logic [63:0]     prod;
    for (int i = 0; i < 4; i++) begin
      zs   = h4[i] + cspl_pkg::DIV3_BIAS;
      prod = {32'b0, zs[31:0]} * {32'b0, cspl_pkg::DIV3_MUL};
      if (div3_4) begin
        c_next[i] = $signed({1'b0, prod[63:33]}) - cspl_pkg::DIV3_OFS;
      end else begin
        c_next[i] = $signed(h4[i][cspl_pkg::C_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      v5 <= v4;
      c5 <= c_next;
    end
  end

  // Stage 6: weight times the low and high parts of each control value.
  always_ff @(posedge clk) begin
    logic signed [XW-1:0] vx;
    if (adv[5]) begin
      for (int i = 0; i < 4; i++) begin
        vx     = XW'(v5[i]);
        pl6[i] <= c5[i] * $signed({1'b0, vx[SPL-1:0]});
        ph6[i] <= c5[i] * $signed(vx[XW-1:SPL]);
      end
    end
  end

  // Stage 7: sum the partial products.
  always_comb begin
    lo_next = '0;
    hi_next = '0;
    for (int i = 0; i < 4; i++) begin
      lo_next = lo_next + LO_W'(pl6[i]);
      hi_next = hi_next + HI_W'(ph6[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      lo7 <= lo_next;
      hi7 <= hi_next;
    end
  end

  // Stage 8: round, rescale and saturate.
  assign lo_rnd = lo7 + $signed(LO_W'(1) << (cspl_pkg::WFRAC - 1));
  assign lq     = lo_rnd[LO_W-1:SPL];
  assign rsum   = RW'(hi7) + RW'(lq);
  assign rsh    = rsum >>> (cspl_pkg::WFRAC - SPL);

  always_comb begin
    if (rsh > RW'(VMAX)) begin
      res_next = VMAX;
    end else if (rsh < RW'(VMIN)) begin
      res_next = VMIN;
    end else begin
      res_next = rsh[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NST]) begin
      out_data <= res_next;
    end
  end

  `ASSERT_IMP(a_ready_when_drained, clk, rst, !out_valid, s_tready,
              "Input not ready although the output register is empty.")
  `ASSERT_NXT(a_tail_reaches_output, clk, rst, vld[NST-1] && adv[NST], out_valid,
              "Item in the last stage did not reach the output register.")
  `ASSERT_IMP(a_param_clamped, clk, rst, vld[0], t1 <= cspl_pkg::WONE,
              "Curve parameter above one after clamping.")
  `ASSERT_IMP(a_div3_in_range, clk, rst, vld[3] && div3_4, h4[0] >= -cspl_pkg::DIV3_BIAS,
              "B-spline numerator below the divide-by-three bias.")

endmodule
